>>> rtl/salc_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the set-associative LRU cache tag store.
// Used by salc_front, salc_queue, salc_back and set_assoc_lru_cache.
package salc_pkg;

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_INVAL  = 1'b1;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_LOOK,
    B_MUL,
    B_OUT
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> rtl/salc_front.sv
`timescale 1ns / 1ps
// Front end: accepts items and splits the address into set and tag.
// Depends on salc_pkg; feeds salc_queue.
module salc_front #(
  parameter int SET_COUNT    = 2048,
  parameter int ADDRESS_BITS = 58,
  parameter int IDX_W        = 11,
  parameter int TAG_W        = 47
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        opcode,
  input  logic [57:0]                 block_address,
  input  logic                        clearing,
  input  salc_pkg::queue_status_t     q_status,
  output logic                        q_push,
  output logic [IDX_W+TAG_W:0]        q_data
);

  localparam int SB       = $clog2(SET_COUNT);
  localparam bit SET_POW2 = (SET_COUNT & (SET_COUNT - 1)) == 0;
  localparam int REM_W    = SB + 1;
  localparam int CHUNK    = 16;
  localparam int NCH      = (ADDRESS_BITS + CHUNK - 1) / CHUNK;
  localparam int XW       = NCH * CHUNK;
  localparam int MBW      = ADDRESS_BITS + 1;
  localparam int PRW      = MBW + CHUNK;
  localparam int PW       = XW + MBW;
  localparam int SH       = ADDRESS_BITS + SB;
  localparam int CW       = SH + 2;
  localparam int CNT_W    = $clog2(NCH + 1);
  // ceil(2^SH / SET_COUNT) gives the exact quotient for any ADDRESS_BITS-bit address
  localparam logic [CW-1:0]  RECIP_W = ((CW'(1) << SH) + CW'(SET_COUNT - 1)) / CW'(SET_COUNT);
  localparam logic [MBW-1:0] RECIP   = RECIP_W[MBW-1:0];

  logic                    f_valid;
  logic                    op_r;
  logic [ADDRESS_BITS-1:0] quo;
  logic [XW-1:0]           xs;
  logic [PW-1:0]           acc;
  logic [PRW-1:0]          part;
  logic [CNT_W-1:0]        cnt;
  logic [TAG_W-1:0]        quot;
  logic [REM_W-1:0]        rem;
  logic                    take;
  logic [IDX_W-1:0]        set_idx;
  logic [TAG_W-1:0]        tag;

  // One 16-bit digit of the reciprocal product, top digit first.
  assign part = PRW'(RECIP) * PRW'(xs[XW-1 -: CHUNK]);

  always_comb begin
    quot = TAG_W'(acc >> SH);
    // the remainder is below 2^REM_W, so the low bits of the difference suffice
    rem  = REM_W'(quo) - REM_W'(REM_W'(quot) * REM_W'(SET_COUNT));
    if (SET_POW2) begin
      set_idx = IDX_W'(quo & ADDRESS_BITS'(SET_COUNT - 1));
      tag     = TAG_W'(quo >> SB);
    end else begin
      set_idx = IDX_W'(rem);
      tag     = quot;
    end
  end

  assign q_push   = f_valid && (cnt == '0) && !q_status.full;
  assign q_data   = {op_r, set_idx, tag};
  assign in_stall = clearing || (f_valid && !q_push);
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
      cnt     <= '0;
    end else begin
      if (take) begin
        f_valid <= 1'b1;
        cnt     <= SET_POW2 ? '0 : CNT_W'(NCH);
      end else if (q_push) begin
        f_valid <= 1'b0;
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op_r <= opcode;
      quo  <= ADDRESS_BITS'(block_address);
      xs   <= XW'(ADDRESS_BITS'(block_address));
      acc  <= '0;
    end else if (cnt != '0) begin
      xs  <= xs << CHUNK;
      acc <= (acc << CHUNK) + PW'(part);
    end
  end

endmodule

>>> rtl/salc_queue.sv
`timescale 1ns / 1ps
// Two-entry queue between the front end and the tag-store back end.
// Depends on salc_pkg for the status struct.
module salc_queue #(
  parameter int WIDTH = 59
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic [WIDTH-1:0]        push_data,
  input  logic                    pop,
  output logic [WIDTH-1:0]        head,
  output salc_pkg::queue_status_t status
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign head         = slots[rd_ptr];
  assign status.full  = count == 2'd2;
  assign status.empty = count == 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && status.full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && status.empty))
    else $error("queue pop while empty");

endmodule

>>> rtl/salc_back.sv
`timescale 1ns / 1ps
// Back end: set memory, tag compare, LRU rank update, counters, result register.
// Depends on salc_pkg; takes classified items from salc_queue.
module salc_back #(
  parameter int SET_COUNT    = 2048,
  parameter int WAY_COUNT    = 16,
  parameter int ADDRESS_BITS = 58,
  parameter int IDX_W        = 11,
  parameter int TAG_W        = 47
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [IDX_W+TAG_W:0]    q_head,
  input  salc_pkg::queue_status_t q_status,
  output logic                    q_pop,
  output logic                    clearing,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    hit,
  output logic                    evicted,
  output logic [57:0]             evicted_block,
  output logic                    not_found,
  output logic [31:0]             hit_count,
  output logic [31:0]             miss_count
);

  localparam int SB       = $clog2(SET_COUNT);
  localparam bit SET_POW2 = (SET_COUNT & (SET_COUNT - 1)) == 0;
  localparam int MW       = (SB > 0) ? SB : 1;
  localparam int RANK_W   = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int ROW_W    = WAY_COUNT * (1 + RANK_W + TAG_W);
  localparam logic [MW-1:0] SetK = MW'(SET_COUNT);

  salc_pkg::back_state_t state, state_next;

  logic [ROW_W-1:0] mem [SET_COUNT];
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] wr_row;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;
  logic [IDX_W-1:0] clr_idx;

  logic             e_op;
  logic [IDX_W-1:0] e_set;
  logic [TAG_W-1:0] e_tag;

  logic [WAY_COUNT-1:0]                 rv, nv;
  logic [WAY_COUNT-1:0][RANK_W-1:0]     rr, nr;
  logic [WAY_COUNT-1:0][TAG_W-1:0]      rt, nt;
  logic [WAY_COUNT-1:0]                 match, finv, last_oh, victim_oh;
  logic                                 lk_hit, lk_full, lk_evict, lk_nf;
  logic [RANK_W-1:0]                    hit_rank;
  logic [TAG_W-1:0]                     ev_tag;
  logic [ADDRESS_BITS-1:0]              ev_addr_fast;

  logic [31:0] hits, misses, hits_next, misses_next;

  logic                    res_hit, res_evicted, res_nf;
  logic [ADDRESS_BITS-1:0] res_blk;
  logic [ADDRESS_BITS-1:0] mul_acc, mul_mc;
  logic [MW-1:0]           mul_k;

  logic slot_free, load_look, load_res, go_mul;

  assign {rv, rr, rt} = rd_row;
  assign clearing     = state == salc_pkg::B_CLEAR;
  assign slot_free    = !out_valid || !out_stall;

  // Lookup and replacement choice.
  always_comb begin
    for (int i = 0; i < WAY_COUNT; i++) begin
      match[i]   = rv[i] && (rt[i] == e_tag);
      last_oh[i] = rr[i] == RANK_W'(WAY_COUNT - 1);
    end
    finv      = ~rv & (~(~rv) + WAY_COUNT'(1));
    lk_hit    = |match;
    lk_full   = &rv;
    victim_oh = lk_full ? last_oh : finv;
    lk_evict  = (e_op == salc_pkg::OP_ACCESS) && !lk_hit && lk_full;
    lk_nf     = (e_op == salc_pkg::OP_INVAL) && !lk_hit;
    hit_rank  = '0;
    ev_tag    = '0;
    for (int i = 0; i < WAY_COUNT; i++) begin
      if (match[i]) begin
        hit_rank = hit_rank | rr[i];
      end
      if (victim_oh[i]) begin
        ev_tag = ev_tag | rt[i];
      end
    end
    ev_addr_fast = (ADDRESS_BITS'(ev_tag) << SB) | ADDRESS_BITS'(e_set);
  end

  // Updated row: valid bits, ranks and tags of every way in parallel.
  always_comb begin
    for (int i = 0; i < WAY_COUNT; i++) begin
      nv[i] = rv[i];
      nr[i] = rr[i];
      nt[i] = rt[i];
      if (e_op == salc_pkg::OP_ACCESS) begin
        if (lk_hit) begin
          if (match[i]) begin
            nr[i] = '0;
          end else if (rv[i] && (rr[i] < hit_rank)) begin
            nr[i] = rr[i] + RANK_W'(1);
          end
        end else if (victim_oh[i]) begin
          nv[i] = 1'b1;
          nt[i] = e_tag;
          nr[i] = '0;
        end else if (rv[i]) begin
          nr[i] = rr[i] + RANK_W'(1);
        end
      end else if (lk_hit) begin
        if (match[i]) begin
          nv[i] = 1'b0;
          nr[i] = '0;
        end else if (rv[i] && (rr[i] > hit_rank)) begin
          nr[i] = rr[i] - RANK_W'(1);
        end
      end
    end
  end

  always_comb begin
    hits_next   = hits;
    misses_next = misses;
    if (e_op == salc_pkg::OP_ACCESS) begin
      if (lk_hit) begin
        if (hits != '1) begin
          hits_next = hits + 32'd1;
        end
      end else if (misses != '1) begin
        misses_next = misses + 32'd1;
      end
    end
  end

  // Next state and control.
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = e_set;
    wr_row     = {nv, nr, nt};
    load_look  = 1'b0;
    load_res   = 1'b0;
    go_mul     = 1'b0;
    unique case (state)
      salc_pkg::B_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
        wr_row  = '0;
        if (clr_idx == IDX_W'(SET_COUNT - 1)) begin
          state_next = salc_pkg::B_IDLE;
        end
      end
      salc_pkg::B_IDLE: begin
        if (!q_status.empty) begin
          q_pop      = 1'b1;
          state_next = salc_pkg::B_LOOK;
        end
      end
      salc_pkg::B_LOOK: begin
        wr_en = 1'b1;
        if (!SET_POW2 && lk_evict) begin
          go_mul     = 1'b1;
          state_next = salc_pkg::B_MUL;
        end else if (slot_free) begin
          load_look  = 1'b1;
          state_next = salc_pkg::B_IDLE;
        end else begin
          state_next = salc_pkg::B_OUT;
        end
      end
      salc_pkg::B_MUL: begin
        if ((mul_k >> 1) == '0) begin
          state_next = salc_pkg::B_OUT;
        end
      end
      salc_pkg::B_OUT: begin
        if (slot_free) begin
          load_res   = 1'b1;
          state_next = salc_pkg::B_IDLE;
        end
      end
      default: state_next = salc_pkg::B_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= salc_pkg::B_CLEAR;
      clr_idx   <= '0;
      hits      <= '0;
      misses    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == salc_pkg::B_CLEAR) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
      if (state == salc_pkg::B_LOOK) begin
        hits   <= hits_next;
        misses <= misses_next;
      end
      if (load_look || load_res) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item latch, pending result and evicted-address rebuild.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      {e_op, e_set, e_tag} <= q_head;
    end
    if (state == salc_pkg::B_LOOK) begin
      res_hit     <= lk_hit;
      res_evicted <= lk_evict;
      res_nf      <= lk_nf;
      res_blk     <= lk_evict ? ev_addr_fast : '0;
    end
    if (go_mul) begin
      mul_acc <= ADDRESS_BITS'(e_set);
      mul_mc  <= ADDRESS_BITS'(ev_tag);
      mul_k   <= SetK;
    end else if (state == salc_pkg::B_MUL) begin
      if (mul_k[0]) begin
        mul_acc <= mul_acc + mul_mc;
        if ((mul_k >> 1) == '0) begin
          res_blk <= mul_acc + mul_mc;
        end
      end else if ((mul_k >> 1) == '0) begin
        res_blk <= mul_acc;
      end
      mul_mc <= mul_mc << 1;
      mul_k  <= mul_k >> 1;
    end
    if (load_look) begin
      hit           <= lk_hit;
      evicted       <= lk_evict;
      evicted_block <= lk_evict ? 58'(ev_addr_fast) : '0;
      not_found     <= lk_nf;
      hit_count     <= hits_next;
      miss_count    <= misses_next;
    end else if (load_res) begin
      hit           <= res_hit;
      evicted       <= res_evicted;
      evicted_block <= 58'(res_blk);
      not_found     <= res_nf;
      hit_count     <= hits;
      miss_count    <= misses;
    end
  end

  always_ff @(posedge clk) begin
    rd_row <= mem[q_head[IDX_W+TAG_W-1:TAG_W]];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  a_hit_unique: assert property (@(posedge clk) disable iff (rst)
    (state == salc_pkg::B_LOOK) |-> $onehot0(match))
    else $error("tag matches in more than one way");
  a_victim_one: assert property (@(posedge clk) disable iff (rst)
    (state == salc_pkg::B_LOOK && e_op == salc_pkg::OP_ACCESS && !lk_hit) |-> $onehot(victim_oh))
    else $error("replacement did not pick exactly one way");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == salc_pkg::B_IDLE))
    else $error("item taken from queue while back end busy");

endmodule

>>> rtl/set_assoc_lru_cache.sv
`timescale 1ns / 1ps
// Set-associative tag store with true LRU replacement. After reset the set memory is
// swept clear, one set per cycle; no item is taken until the sweep is done.
// With a power-of-two SET_COUNT an item passes through two back-end states (set
// read in IDLE, then compare and row write-back in LOOK), which set the rate while
// the output does not stall. Otherwise the front end forms set and tag by multiplying
// the address with a reciprocal of SET_COUNT, 16 bits per cycle, and takes no new item
// until the last is pushed, overlapped with the back end through a two-entry queue; an
// eviction then adds shift-add steps in the MUL state to rebuild the evicted address.
module set_assoc_lru_cache #(
  parameter int SET_COUNT    = 2048,
  parameter int WAY_COUNT    = 16,
  parameter int ADDRESS_BITS = 58
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [57:0] block_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic        evicted,
  output logic [57:0] evicted_block,
  output logic        not_found,
  output logic [31:0] hit_count,
  output logic [31:0] miss_count
);

  localparam int SB     = $clog2(SET_COUNT);
  localparam bit POW2   = (SET_COUNT & (SET_COUNT - 1)) == 0;
  localparam int IDX_W  = (SB > 0) ? SB : 1;
  localparam int TAG_R  = ADDRESS_BITS - SB + (POW2 ? 0 : 1);
  localparam int TAG_W  = (TAG_R > 0) ? TAG_R : 1;
  localparam int ENT_W  = 1 + IDX_W + TAG_W;

  salc_pkg::queue_status_t q_status;
  logic                    q_push, q_pop, clearing;
  logic [ENT_W-1:0]        q_data, q_head;

  salc_front #(
    .SET_COUNT(SET_COUNT), .ADDRESS_BITS(ADDRESS_BITS), .IDX_W(IDX_W), .TAG_W(TAG_W)
  ) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .block_address(block_address), .clearing(clearing),
    .q_status(q_status), .q_push(q_push), .q_data(q_data)
  );

  salc_queue #(.WIDTH(ENT_W)) u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_data(q_data),
    .pop(q_pop), .head(q_head), .status(q_status)
  );

  salc_back #(
    .SET_COUNT(SET_COUNT), .WAY_COUNT(WAY_COUNT), .ADDRESS_BITS(ADDRESS_BITS),
    .IDX_W(IDX_W), .TAG_W(TAG_W)
  ) u_back (
    .clk(clk), .rst(rst), .q_head(q_head), .q_status(q_status), .q_pop(q_pop),
    .clearing(clearing), .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .evicted(evicted), .evicted_block(evicted_block),
    .not_found(not_found), .hit_count(hit_count), .miss_count(miss_count)
  );

endmodule
